// ===== sv/mlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared widths, codes, word types and curve tables of the dense
// multilayer perceptron inference engine.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam int MAX_LAYERS = 4;
    localparam int MAX_UNITS  = 64;
    localparam int FRAC_BITS  = 12;

    localparam int DATA_W  = 16;
    localparam int LAYER_W = $clog2(MAX_LAYERS);
    localparam int UNIT_W  = $clog2(MAX_UNITS);
    localparam int CNT_W   = UNIT_W + 1;
    localparam int WADDR_W = LAYER_W + 2 * UNIT_W;
    localparam int BADDR_W = LAYER_W + UNIT_W;
    localparam int LADDR_W = UNIT_W + 1;
    localparam int ACC_W   = 2 * DATA_W + UNIT_W + 2;
    localparam int E_W     = 17;
    localparam int SUM_W   = E_W + UNIT_W;
    localparam int NUM_W   = E_W + FRAC_BITS + 1;
    localparam int DEN_W   = SUM_W + 1;
    localparam int PRE_W   = E_W + 1 + DATA_W;
    localparam int TAB_W   = 18;
    localparam int SEG_C   = FRAC_BITS - 1;
    localparam int SEG_E   = FRAC_BITS - 2;
    localparam int CURVE_SH = 15;
    localparam int U_W     = FRAC_BITS + 5;
    localparam int LEAKY_Q = ((1 << FRAC_BITS) + 50) / 100;

    // Opcodes of an input word
    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_BIAS    = 2'd1;
    localparam logic [1:0] OP_FEATURE = 2'd2;

    // Activation codes
    localparam logic [2:0] ACT_RELU    = 3'd0;
    localparam logic [2:0] ACT_LEAKY   = 3'd1;
    localparam logic [2:0] ACT_SIGMOID = 3'd2;
    localparam logic [2:0] ACT_TANH    = 3'd3;
    localparam logic [2:0] ACT_LINEAR  = 3'd4;
    localparam logic [2:0] ACT_SOFTMAX = 3'd5;

    // Register indexes
    localparam logic [1:0] REG_INPUT_LENGTH    = 2'd0;
    localparam logic [1:0] REG_LAYER_COUNT     = 2'd1;
    localparam logic [1:0] REG_LAYER_WIDTHS    = 2'd2;
    localparam logic [1:0] REG_LAYER_FUNCTIONS = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         layer_index;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [15:0] value;
        logic               last_feature;
    } mlp_item_t;

    typedef struct packed {
        logic [5:0]         unit_index;
        logic signed [15:0] activation_value;
        logic               saturated;
        logic               last_unit;
    } mlp_result_t;

    // Curve tables, signed Q1.16, 33 points
    localparam logic signed [TAB_W-1:0] SIG_TAB [0:32] = '{
        18'sd22, 18'sd36, 18'sd60, 18'sd98, 18'sd162, 18'sd267, 18'sd439, 18'sd720,
        18'sd1179, 18'sd1921, 18'sd3108, 18'sd4971, 18'sd7812, 18'sd11955,
        18'sd17625, 18'sd24743, 18'sd32768, 18'sd40793, 18'sd47911, 18'sd53581,
        18'sd57724, 18'sd60565, 18'sd62428, 18'sd63615, 18'sd64357, 18'sd64816,
        18'sd65097, 18'sd65269, 18'sd65374, 18'sd65438, 18'sd65476, 18'sd65500,
        18'sd65514};

    localparam logic signed [TAB_W-1:0] TANH_TAB [0:32] = '{
        -18'sd65536, -18'sd65536, -18'sd65536, -18'sd65536, -18'sd65535,
        -18'sd65534, -18'sd65530, -18'sd65520, -18'sd65492, -18'sd65417,
        -18'sd65212, -18'sd64659, -18'sd63179, -18'sd59320, -18'sd49912,
        -18'sd30285, 18'sd0, 18'sd30285, 18'sd49912, 18'sd59320, 18'sd63179,
        18'sd64659, 18'sd65212, 18'sd65417, 18'sd65492, 18'sd65520, 18'sd65530,
        18'sd65534, 18'sd65535, 18'sd65536, 18'sd65536, 18'sd65536, 18'sd65536};

    localparam logic signed [TAB_W-1:0] EXP_TAB [0:32] = '{
        18'sd22, 18'sd28, 18'sd36, 18'sd47, 18'sd60, 18'sd77, 18'sd99, 18'sd127,
        18'sd162, 18'sd209, 18'sd268, 18'sd344, 18'sd442, 18'sd567, 18'sd728,
        18'sd935, 18'sd1200, 18'sd1541, 18'sd1979, 18'sd2541, 18'sd3263,
        18'sd4190, 18'sd5380, 18'sd6907, 18'sd8869, 18'sd11388, 18'sd14623,
        18'sd18776, 18'sd24109, 18'sd30957, 18'sd39750, 18'sd51039, 18'sd65536};

endpackage

// ===== sv/mlp_ram.sv =====
// ----------------------------------------------------------------------------
// mlp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mlp_act.sv =====
// ----------------------------------------------------------------------------
// mlp_act
// Two-stage activation unit: relu, leaky relu, piecewise-linear sigmoid,
// tanh and exp (for softmax), or pass-through.
// ----------------------------------------------------------------------------
module mlp_act (
    input  logic                clk,
    input  logic [2:0]          code,
    input  logic signed [16:0]  x,
    output logic signed [17:0]  y
);
    import mlp_pkg::*;

    localparam logic signed [17:0] CURVE_LO = 18'(-(8 <<< FRAC_BITS));
    localparam logic signed [17:0] CURVE_HI = 18'((8 <<< FRAC_BITS) - 1);

    logic signed [17:0]      xc;
    logic [U_W-1:0]          u;
    logic [5:0]              k;
    logic [5:0]              kn;
    logic [SEG_C-1:0]        frac;
    logic signed [TAB_W-1:0] base;
    logic signed [TAB_W-1:0] diff;

    logic [2:0]              code_s1_reg;
    logic signed [16:0]      x_s1_reg;
    logic signed [TAB_W-1:0] base_s1_reg;
    logic signed [TAB_W-1:0] diff_s1_reg;
    logic [SEG_C-1:0]        frac_s1_reg;

    logic signed [31:0]      curve_v;
    logic signed [31:0]      exp_v;
    logic signed [31:0]      leak_p;
    logic signed [31:0]      curve_y;
    logic signed [31:0]      exp_y;
    logic signed [31:0]      leak_y;
    logic signed [17:0]      y_next;
    logic signed [17:0]      y_reg;

    // Clamp, find the segment and look up its end points
    always_comb
    begin
        xc = 18'(x);
        if (xc < CURVE_LO)
        begin
            xc = CURVE_LO;
        end
        if (code != ACT_SOFTMAX && xc > CURVE_HI)
        begin
            xc = CURVE_HI;
        end
        u = U_W'(xc - CURVE_LO);
        if (code == ACT_SOFTMAX)
        begin
            k    = 6'(u >> SEG_E);
            frac = SEG_C'(u[SEG_E-1:0]);
        end
        else
        begin
            k    = 6'(u >> SEG_C);
            frac = u[SEG_C-1:0];
        end
        kn = (k >= 6'd32) ? 6'd32 : k + 6'd1;
        case (code)
            ACT_SIGMOID:
            begin
                base = SIG_TAB[k];
                diff = SIG_TAB[kn] - SIG_TAB[k];
            end
            ACT_TANH:
            begin
                base = TANH_TAB[k];
                diff = TANH_TAB[kn] - TANH_TAB[k];
            end
            ACT_SOFTMAX:
            begin
                base = EXP_TAB[k];
                diff = EXP_TAB[kn] - EXP_TAB[k];
            end
            default:
            begin
                base = '0;
                diff = '0;
            end
        endcase
    end

    // Hold the segment data for the interpolation stage
    always_ff @(posedge clk)
    begin
        code_s1_reg <= code;
        x_s1_reg    <= x;
        base_s1_reg <= base;
        diff_s1_reg <= diff;
        frac_s1_reg <= frac;
    end

    // Interpolate, round and select the result
    always_comb
    begin
        curve_v = (32'(base_s1_reg) <<< SEG_C)
                + 32'(diff_s1_reg) * $signed({1'b0, frac_s1_reg});
        exp_v   = (32'(base_s1_reg) <<< SEG_E)
                + 32'(diff_s1_reg) * $signed({1'b0, frac_s1_reg});
        leak_p  = 32'(x_s1_reg) * 32'(LEAKY_Q);
        curve_y = (curve_v + 32'(1 <<< (CURVE_SH - 1))) >>> CURVE_SH;
        exp_y   = (exp_v + 32'(1 <<< (SEG_E - 1))) >>> SEG_E;
        leak_y  = (leak_p + 32'(1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        case (code_s1_reg)
            ACT_RELU:    y_next = (x_s1_reg > 17'sd0) ? 18'(x_s1_reg) : 18'sd0;
            ACT_LEAKY:   y_next = (x_s1_reg > 17'sd0) ? 18'(x_s1_reg) : 18'(leak_y);
            ACT_SIGMOID,
            ACT_TANH:    y_next = 18'(curve_y);
            ACT_SOFTMAX: y_next = 18'(exp_y);
            default:     y_next = 18'(x_s1_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ===== sv/mlp_div.sv =====
// ----------------------------------------------------------------------------
// mlp_div
// Restoring unsigned divider, one quotient bit per cycle, for softmax
// normalization.
// ----------------------------------------------------------------------------
module mlp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mlp_pkg::NUM_W-1:0]  num,
    input  logic [mlp_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [mlp_pkg::NUM_W-1:0]  quot
);
    import mlp_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  qn_reg, qn_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    trial;

    // Shift in one numerator bit, subtract where it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        qn_next   = qn_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, qn_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            qn_next   = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                qn_next  = {qn_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = DEN_W'(trial);
                qn_next  = {qn_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qn_reg  <= qn_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = qn_reg;

endmodule

// ===== sv/mlp_forward_inference.sv =====
// ----------------------------------------------------------------------------
// mlp_forward_inference
// Dense multilayer perceptron inference engine, Q4.12 fixed point.
// ----------------------------------------------------------------------------
// Weight, bias and non-final feature words are taken one per cycle. The
// feature word flagged last starts a sample; the engine then stalls input
// until every result word of the sample has been taken. Each layer runs a
// multiply-accumulate pass through the one shared multiplier, fed by one
// weight memory read per cycle, then a pass over its units for relu, leaky,
// sigmoid, tanh or linear, or for softmax a max pass, an exp pass and a
// bit-serial division per unit. Result words are then sent one at a time,
// each held while result_stall is high.
module mlp_forward_inference (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  mlp_pkg::mlp_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output mlp_pkg::mlp_result_t result
);
    import mlp_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_BIAS  = 21'h000002,
        S_BINIT = 21'h000004,
        S_MAC   = 21'h000008,
        S_FIN   = 21'h000010,
        S_ARD   = 21'h000020,
        S_AS1   = 21'h000040,
        S_AS2   = 21'h000080,
        S_AWR   = 21'h000100,
        S_MRD   = 21'h000200,
        S_MCMP  = 21'h000400,
        S_ERD   = 21'h000800,
        S_ES1   = 21'h001000,
        S_ES2   = 21'h002000,
        S_EWR   = 21'h004000,
        S_DRD   = 21'h008000,
        S_DLD   = 21'h010000,
        S_DWT   = 21'h020000,
        S_ORD   = 21'h040000,
        S_OLD   = 21'h080000,
        S_OWT   = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [6:0]  input_length_reg;
    logic [2:0]  layer_count_reg;
    logic [23:0] layer_widths_reg;
    logic [11:0] layer_functions_reg;

    // Sequencer registers
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   n_in_reg, n_in_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [DATA_W-1:0]   mx_reg, mx_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [DATA_W:0]            pword_reg, pword_next;
    mlp_result_t                result_reg, result_next;
    logic                       result_valid_reg, result_valid_next;

    // Memory ports
    logic               w_we, b_we, f_we, l_we, p_we;
    logic [WADDR_W-1:0] w_waddr, w_raddr;
    logic [BADDR_W-1:0] b_waddr, b_raddr;
    logic [UNIT_W-1:0]  f_raddr;
    logic [LADDR_W-1:0] l_waddr, l_raddr;
    logic [DATA_W-1:0]  w_rdata, b_rdata, f_rdata, l_rdata, l_wdata;
    logic [PRE_W-1:0]   p_rdata, p_wdata;

    // Activation unit and divider
    logic [2:0]         act_code;
    logic signed [16:0] act_x;
    logic signed [17:0] act_y;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;

    // Derived values
    logic               item_acc;
    logic               cfg_wr;
    logic [CNT_W-1:0]   n_in0;
    logic [2:0]         n_layers;
    logic [CNT_W-1:0]   n_out;
    logic [2:0]         func;
    logic               j_last;
    logic               layer_last;
    logic               issue;
    logic signed [DATA_W-1:0] src;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [DATA_W-1:0] z;
    logic                     clip;
    logic signed [DATA_W-1:0] p_z;
    logic [E_W-1:0]           p_e;

    assign item_acc   = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_length_reg    <= 7'd64;
            layer_count_reg     <= 3'd1;
            layer_widths_reg    <= '0;
            layer_functions_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_INPUT_LENGTH:    input_length_reg    <= pwdata[6:0];
                REG_LAYER_COUNT:     layer_count_reg     <= pwdata[2:0];
                REG_LAYER_WIDTHS:    layer_widths_reg    <= pwdata[23:0];
                REG_LAYER_FUNCTIONS: layer_functions_reg <= pwdata[11:0];
                default:             ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_INPUT_LENGTH:    prdata = 32'(input_length_reg);
            REG_LAYER_COUNT:     prdata = 32'(layer_count_reg);
            REG_LAYER_WIDTHS:    prdata = 32'(layer_widths_reg);
            REG_LAYER_FUNCTIONS: prdata = 32'(layer_functions_reg);
            default:             prdata = '0;
        endcase
    end

    // Clamp lengths and pick the current layer's shape
    always_comb
    begin
        if (input_length_reg == 7'd0)
        begin
            n_in0 = CNT_W'(1);
        end
        else if (input_length_reg > 7'(MAX_UNITS))
        begin
            n_in0 = CNT_W'(MAX_UNITS);
        end
        else
        begin
            n_in0 = CNT_W'(input_length_reg);
        end
        if (layer_count_reg == 3'd0)
        begin
            n_layers = 3'd1;
        end
        else if (layer_count_reg > 3'(MAX_LAYERS))
        begin
            n_layers = 3'(MAX_LAYERS);
        end
        else
        begin
            n_layers = layer_count_reg;
        end
        n_out      = CNT_W'(layer_widths_reg[6*layer_reg +: 6]) + CNT_W'(1);
        func       = layer_functions_reg[3*layer_reg +: 3];
        j_last     = (j_reg + CNT_W'(1) == n_out);
        layer_last = (3'(layer_reg) + 3'd1 == n_layers);
        issue      = (i_reg < n_in_reg);
    end

    // Memory addressing
    assign w_we    = item_acc && item.opcode == OP_WEIGHT;
    assign w_waddr = {item.layer_index, item.row_index, item.col_index};
    assign w_raddr = {layer_reg, i_reg[UNIT_W-1:0], j_reg[UNIT_W-1:0]};
    assign b_we    = item_acc && item.opcode == OP_BIAS;
    assign b_waddr = {item.layer_index, item.col_index};
    assign b_raddr = {layer_reg, j_reg[UNIT_W-1:0]};
    assign f_we    = item_acc && item.opcode == OP_FEATURE;
    assign f_raddr = i_reg[UNIT_W-1:0];
    assign l_waddr = {layer_reg[0], j_reg[UNIT_W-1:0]};
    assign l_raddr = (state_reg == S_MAC) ? {~layer_reg[0], i_reg[UNIT_W-1:0]}
                                          : {layer_reg[0], j_reg[UNIT_W-1:0]};
    assign p_z     = $signed(p_rdata[DATA_W-1:0]);
    assign p_e     = p_rdata[PRE_W-1 -: E_W];
    assign src     = (layer_reg == '0) ? $signed(f_rdata) : $signed(l_rdata);

    // Round and saturate the accumulated sum
    always_comb
    begin
        rnd  = (acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        clip = 1'b0;
        if (rnd > ACC_W'(32767))
        begin
            z    = 16'sh7FFF;
            clip = 1'b1;
        end
        else if (rnd < -ACC_W'(32768))
        begin
            z    = -16'sh8000;
            clip = 1'b1;
        end
        else
        begin
            z = DATA_W'(rnd);
        end
    end

    // Feed the activation unit
    always_comb
    begin
        if (state_reg == S_ES1)
        begin
            act_code = ACT_SOFTMAX;
            act_x    = 17'(p_z) - 17'(mx_reg);
        end
        else
        begin
            act_code = func;
            act_x    = 17'(p_z);
        end
        div_num = (NUM_W'(p_e) << (FRAC_BITS + 1)) + NUM_W'(sum_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        layer_next        = layer_reg;
        j_next            = j_reg;
        i_next            = i_reg;
        n_in_next         = n_in_reg;
        v1_next           = 1'b0;
        v2_next           = v1_reg;
        acc_next          = acc_reg;
        mx_next           = mx_reg;
        sum_next          = sum_reg;
        pword_next        = pword_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        l_we              = 1'b0;
        l_wdata           = act_y[DATA_W-1:0];
        p_we              = 1'b0;
        p_wdata           = {E_W'(0), clip, z};
        div_start         = 1'b0;

        // Accumulate the registered product when v2_reg marks it valid
        if (v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (f_we && item.last_feature)
                begin
                    layer_next = '0;
                    j_next     = '0;
                    n_in_next  = n_in0;
                    state_next = S_BIAS;
                end
            end
            S_BIAS:
            begin
                state_next = S_BINIT;
            end
            S_BINIT:
            begin
                acc_next   = ACC_W'($signed(b_rdata)) <<< FRAC_BITS;
                i_next     = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (issue)
                begin
                    i_next  = i_reg + CNT_W'(1);
                    v1_next = 1'b1;
                end
                else if (!v1_reg && !v2_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                p_we = 1'b1;
                if (j_last)
                begin
                    j_next     = '0;
                    state_next = (func == ACT_SOFTMAX) ? S_MRD : S_ARD;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_BIAS;
                end
            end
            S_ARD:  state_next = S_AS1;
            S_AS1:  state_next = S_AS2;
            S_AS2:  state_next = S_AWR;
            S_AWR:
            begin
                l_we = 1'b1;
                if (!j_last)
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_ARD;
                end
                else
                begin
                    j_next = '0;
                    if (layer_last)
                    begin
                        state_next = S_ORD;
                    end
                    else
                    begin
                        layer_next = layer_reg + LAYER_W'(1);
                        n_in_next  = n_out;
                        state_next = S_BIAS;
                    end
                end
            end
            S_MRD:  state_next = S_MCMP;
            S_MCMP:
            begin
                if (j_reg == '0 || p_z > mx_reg)
                begin
                    mx_next = p_z;
                end
                if (j_last)
                begin
                    j_next     = '0;
                    sum_next   = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_MRD;
                end
            end
            S_ERD:  state_next = S_ES1;
            S_ES1:
            begin
                pword_next = p_rdata[DATA_W:0];
                state_next = S_ES2;
            end
            S_ES2:  state_next = S_EWR;
            S_EWR:
            begin
                p_we     = 1'b1;
                p_wdata  = {act_y[E_W-1:0], pword_reg};
                sum_next = sum_reg + SUM_W'(act_y[E_W-1:0]);
                if (j_last)
                begin
                    j_next     = '0;
                    state_next = S_DRD;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_ERD;
                end
            end
            S_DRD:  state_next = S_DLD;
            S_DLD:
            begin
                div_start  = 1'b1;
                state_next = S_DWT;
            end
            S_DWT:
            begin
                l_wdata = (div_quot > NUM_W'(32767)) ? 16'h7FFF : div_quot[DATA_W-1:0];
                if (div_done)
                begin
                    l_we = 1'b1;
                    if (!j_last)
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_DRD;
                    end
                    else
                    begin
                        j_next = '0;
                        if (layer_last)
                        begin
                            state_next = S_ORD;
                        end
                        else
                        begin
                            layer_next = layer_reg + LAYER_W'(1);
                            n_in_next  = n_out;
                            state_next = S_BIAS;
                        end
                    end
                end
            end
            S_ORD:  state_next = S_OLD;
            S_OLD:
            begin
                result_next.unit_index       = j_reg[UNIT_W-1:0];
                result_next.activation_value = $signed(l_rdata);
                result_next.saturated        = p_rdata[DATA_W];
                result_next.last_unit        = j_last;
                result_valid_next            = 1'b1;
                state_next                   = S_OWT;
            end
            S_OWT:
            begin
                if (!result_stall)
                begin
                    result_valid_next = 1'b0;
                    if (j_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            layer_reg        <= '0;
            j_reg            <= '0;
            i_reg            <= '0;
            n_in_reg         <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            layer_reg        <= layer_next;
            j_reg            <= j_next;
            i_reg            <= i_next;
            n_in_reg         <= n_in_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= src * $signed(w_rdata);
        acc_reg    <= acc_next;
        mx_reg     <= mx_next;
        sum_reg    <= sum_next;
        pword_reg  <= pword_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LAYERS * MAX_UNITS * MAX_UNITS)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (item.value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LAYERS * MAX_UNITS)) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (item.value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNITS)) u_feature_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (item.col_index),
        .wdata (item.value),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_UNITS)) u_layer_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    mlp_ram #(.WIDTH(PRE_W), .DEPTH(MAX_UNITS)) u_preact_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (j_reg[UNIT_W-1:0]),
        .wdata (p_wdata),
        .raddr (j_reg[UNIT_W-1:0]),
        .rdata (p_rdata)
    );

    mlp_act u_act (
        .clk  (clk),
        .code (act_code),
        .x    (act_x),
        .y    (act_y)
    );

    mlp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({sum_reg, 1'b0}),
        .done  (div_done),
        .quot  (div_quot)
    );

endmodule

// ===== verif/mlp_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_result_checker
// Watches the register port and both word channels of the inference engine,
// predicts every result word from its own copy of the stores and registers,
// and compares each accepted result word field by field in order.
// ----------------------------------------------------------------------------
module mlp_result_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  mlp_pkg::mlp_item_t   item,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  mlp_pkg::mlp_result_t result,
    output int                   errors,
    output int                   pending,
    output int                   samples,
    output int                   results_seen
);
    import mlp_pkg::*;

    localparam int TAB_SIG  = 0;
    localparam int TAB_TANH = 1;
    localparam int TAB_EXP  = 2;

    // Register copies
    logic [6:0]  in_len;
    logic [2:0]  n_layers;
    logic [23:0] widths;
    logic [11:0] funcs;

    // Store copies
    logic signed [15:0] wts [0:MAX_LAYERS-1][0:MAX_UNITS-1][0:MAX_UNITS-1];
    logic signed [15:0] biases [0:MAX_LAYERS-1][0:MAX_UNITS-1];
    logic signed [15:0] feats [0:MAX_UNITS-1];
    logic signed [15:0] acts [0:1][0:MAX_UNITS-1];
    longint             pre [0:MAX_UNITS-1];
    bit                 clipped [0:MAX_UNITS-1];

    mlp_result_t expected_units [$];

    assign pending = expected_units.size();

    initial
    begin
        errors = 0;
        samples = 0;
        results_seen = 0;
        foreach (wts[l, i, j]) wts[l][i][j] = '0;
        foreach (biases[l, j]) biases[l][j] = '0;
        foreach (feats[k]) feats[k] = '0;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint tab_at(int sel, longint k);
        case (sel)
            TAB_SIG:  return longint'(SIG_TAB[k]);
            TAB_TANH: return longint'(TANH_TAB[k]);
            default:  return longint'(EXP_TAB[k]);
        endcase
    endfunction

    // Piecewise-linear lookup, scaled by 2^seg
    function automatic longint interp(int sel, longint u, int seg);
        longint k;
        longint frac;
        k = u >>> seg;
        frac = u - (k <<< seg);
        if (k >= 32) return tab_at(sel, 32) <<< seg;
        return (tab_at(sel, k) <<< seg) + (tab_at(sel, k + 1) - tab_at(sel, k)) * frac;
    endfunction

    function automatic longint squash(int sel, longint x);
        longint lo;
        longint hi;
        lo = -(longint'(8) <<< FRAC_BITS);
        hi = (longint'(8) <<< FRAC_BITS) - 1;
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return round_shift(interp(sel, x - lo, SEG_C), CURVE_SH);
    endfunction

    // Run one sample through all layers and queue its result words
    function automatic void infer_sample();
        int          n_in;
        int          n_out;
        int          nl;
        int          cur;
        logic [2:0]  code;
        longint      acc;
        longint      r;
        longint      y;
        longint      mx;
        longint      sum;
        longint      floor8;
        longint      d;
        longint      e [0:MAX_UNITS-1];
        mlp_result_t w;
        n_in = (in_len < 1) ? 1 : ((in_len > MAX_UNITS) ? MAX_UNITS : int'(in_len));
        nl = (n_layers < 1) ? 1 : ((n_layers > MAX_LAYERS) ? MAX_LAYERS : int'(n_layers));
        cur = 0;
        n_out = 1;
        for (int k = 0; k < n_in; k++) acts[0][k] = feats[k];
        for (int l = 0; l < nl; l++)
        begin
            n_out = int'((widths >> (6 * l)) & 24'h3F) + 1;
            code = 3'((funcs >> (3 * l)) & 12'h7);
            for (int j = 0; j < n_out; j++)
            begin
                acc = longint'(biases[l][j]) <<< FRAC_BITS;
                for (int i = 0; i < n_in; i++)
                    acc += longint'(acts[cur][i]) * longint'(wts[l][i][j]);
                r = round_shift(acc, FRAC_BITS);
                pre[j] = clip16(r);
                clipped[j] = (pre[j] != r);
            end
            if (code == ACT_SOFTMAX)
            begin
                mx = pre[0];
                sum = 0;
                floor8 = -(longint'(8) <<< FRAC_BITS);
                for (int j = 1; j < n_out; j++)
                    if (pre[j] > mx) mx = pre[j];
                for (int j = 0; j < n_out; j++)
                begin
                    d = pre[j] - mx;
                    if (d < floor8) d = floor8;
                    e[j] = round_shift(interp(TAB_EXP, d - floor8, SEG_E), SEG_E);
                    sum += e[j];
                end
                for (int j = 0; j < n_out; j++)
                    acts[cur ^ 1][j] =
                        16'(clip16((e[j] * (longint'(2) <<< FRAC_BITS) + sum) / (2 * sum)));
            end
            else
            begin
                for (int j = 0; j < n_out; j++)
                begin
                    case (code)
                        ACT_RELU:    y = (pre[j] > 0) ? pre[j] : 0;
                        ACT_LEAKY:   y = (pre[j] > 0) ? pre[j] :
                                         round_shift(pre[j] * longint'(LEAKY_Q), FRAC_BITS);
                        ACT_SIGMOID: y = squash(TAB_SIG, pre[j]);
                        ACT_TANH:    y = squash(TAB_TANH, pre[j]);
                        default:     y = pre[j];
                    endcase
                    acts[cur ^ 1][j] = 16'(clip16(y));
                end
            end
            cur ^= 1;
            n_in = n_out;
        end
        for (int k = 0; k < n_out; k++)
        begin
            w.unit_index = 6'(k);
            w.activation_value = acts[cur][k];
            w.saturated = clipped[k];
            w.last_unit = (k + 1 == n_out);
            expected_units.insert(expected_units.size(), w);
        end
    endfunction

    // Track registers and stores, predict on the starting feature word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len <= 7'd64;
            n_layers <= 3'd1;
            widths <= '0;
            funcs <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_INPUT_LENGTH:    in_len <= pwdata[6:0];
                    REG_LAYER_COUNT:     n_layers <= pwdata[2:0];
                    REG_LAYER_WIDTHS:    widths <= pwdata[23:0];
                    REG_LAYER_FUNCTIONS: funcs <= pwdata[11:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                case (item.opcode)
                    OP_WEIGHT:
                        wts[item.layer_index][item.row_index][item.col_index] = item.value;
                    OP_BIAS:
                        biases[item.layer_index][item.col_index] = item.value;
                    OP_FEATURE:
                    begin
                        feats[item.col_index] = item.value;
                        if (item.last_feature)
                        begin
                            infer_sample();
                            samples++;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        mlp_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_units.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word %p", $time, result);
            end
            else
            begin
                want = expected_units.pop_front();
                if (want.unit_index !== result.unit_index)
                begin
                    errors++;
                    $display("%0t: unit_index expected %0d actual %0d", $time,
                             want.unit_index, result.unit_index);
                end
                if (want.activation_value !== result.activation_value)
                begin
                    errors++;
                    $display("%0t: activation_value expected %0d actual %0d (unit %0d)",
                             $time, want.activation_value, result.activation_value,
                             want.unit_index);
                end
                if (want.saturated !== result.saturated)
                begin
                    errors++;
                    $display("%0t: saturated expected %0b actual %0b (unit %0d)", $time,
                             want.saturated, result.saturated, want.unit_index);
                end
                if (want.last_unit !== result.last_unit)
                begin
                    errors++;
                    $display("%0t: last_unit expected %0b actual %0b (unit %0d)", $time,
                             want.last_unit, result.last_unit, want.unit_index);
                end
            end
        end
    end

endmodule

// ===== verif/mlp_forward_inference_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_forward_inference_test
// Drives network setups through the register port, loads every weight and
// bias each setup reads, then streams samples with random idling on both
// channels; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module mlp_forward_inference_test;
    import mlp_pkg::*;

    localparam int STALL_LIMIT = 200000;

    // Opcode with no defined meaning
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_stall;
    mlp_item_t   item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    mlp_result_t result;

    int errors;
    int pending;
    int samples;
    int results_seen;
    int words_sent = 0;
    int send_gap_pct = 37;
    int recv_gap_pct = 64;
    int quiet_cycles = 0;

    // Effective network shape of the current setup
    int net_in;
    int net_layers;
    int net_units [0:MAX_LAYERS-1];

    mlp_forward_inference dut (.*);

    mlp_result_checker checker_i (.*);

    always #5 clk = ~clk;

    // Idling schedule follows the number of words sent
    always @(posedge clk)
    begin
        if (words_sent < 95)
        begin
            send_gap_pct <= 37;
            recv_gap_pct <= 64;
        end
        else if (words_sent < 190)
        begin
            send_gap_pct <= 64;
            recv_gap_pct <= 37;
        end
        else
        begin
            send_gap_pct <= 0;
            recv_gap_pct <= 0;
        end
        result_stall <= ($urandom_range(99) < recv_gap_pct);
    end

    // Watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("mlp_forward_inference regression: fail");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(logic [1:0] op, logic [1:0] lay, logic [5:0] row,
                             logic [5:0] col, logic signed [15:0] val, logic last);
        mlp_item_t w;
        w.opcode = op;
        w.layer_index = lay;
        w.row_index = row;
        w.col_index = col;
        w.value = val;
        w.last_feature = last;
        if ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do @(posedge clk); while (item_stall);
        words_sent++;
    endtask

    function automatic logic signed [15:0] rand_value(int mag);
        if ($urandom_range(15) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 2 * mag)) - mag);
    endfunction

    // Occasional words that must not start a sample
    task automatic maybe_noise();
        case ($urandom_range(11))
            0: send_word(OP_RESERVED, 2'($urandom), 6'($urandom), 6'($urandom),
                         16'($urandom), 1'($urandom));
            1: send_word(OP_BIAS, 2'($urandom), 6'($urandom), 6'($urandom),
                         16'($urandom), 1'b1);
            2: send_word(OP_WEIGHT, 2'($urandom), 6'($urandom), 6'($urandom),
                         16'($urandom), 1'b1);
            default: ;
        endcase
    endtask

    // Wait for all results, drain, then program a new network shape
    task automatic set_network(int len, int layers, logic [23:0] widths,
                               logic [11:0] funcs);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        reg_write(REG_INPUT_LENGTH, 32'(len));
        reg_write(REG_LAYER_COUNT, 32'(layers));
        reg_write(REG_LAYER_WIDTHS, 32'(widths));
        reg_write(REG_LAYER_FUNCTIONS, 32'(funcs));
        net_in = (len < 1) ? 1 : ((len > MAX_UNITS) ? MAX_UNITS : len);
        net_layers = (layers < 1) ? 1 : ((layers > MAX_LAYERS) ? MAX_LAYERS : layers);
        for (int l = 0; l < MAX_LAYERS; l++)
            net_units[l] = int'((widths >> (6 * l)) & 24'h3F) + 1;
    endtask

    // Write every weight and bias the current shape reads
    task automatic load_network(int mag);
        int n_in;
        n_in = net_in;
        for (int l = 0; l < net_layers; l++)
        begin
            for (int j = 0; j < net_units[l]; j++)
            begin
                send_word(OP_BIAS, 2'(l), 6'($urandom), 6'(j), rand_value(mag), 1'b0);
                for (int i = 0; i < n_in; i++)
                    send_word(OP_WEIGHT, 2'(l), 6'(i), 6'(j), rand_value(mag), 1'b0);
            end
            n_in = net_units[l];
        end
    endtask

    task automatic run_sample(int mag);
        for (int k = 0; k < net_in; k++)
        begin
            maybe_noise();
            send_word(OP_FEATURE, 2'($urandom), 6'($urandom), 6'(k), rand_value(mag),
                      k == net_in - 1);
        end
    endtask

    initial
    begin
        logic [23:0] widths;
        int          layers;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Saturating relu layer, extreme words and ignored words
        set_network(3, 1, 24'd2, 12'(ACT_RELU));
        load_network(32767);
        send_word(OP_WEIGHT, 2'd0, 6'd0, 6'd0, 16'sh8000, 1'b0);
        send_word(OP_BIAS, 2'd0, 6'd0, 6'd1, 16'sh7FFF, 1'b1);
        send_word(OP_RESERVED, 2'd3, 6'd63, 6'd63, 16'shFFFF, 1'b1);
        send_word(OP_WEIGHT, 2'd3, 6'd63, 6'd63, 16'sh7FFF, 1'b0);
        send_word(OP_FEATURE, 2'd0, 6'd0, 6'd0, 16'sh7FFF, 1'b0);
        send_word(OP_FEATURE, 2'd0, 6'd0, 6'd1, 16'sh8000, 1'b0);
        send_word(OP_FEATURE, 2'd3, 6'd63, 6'd2, 16'sh7FFF, 1'b1);
        run_sample(32767);

        // Zero lengths clamp to one; 64 softmax units
        set_network(0, 0, 24'd63, 12'(ACT_SOFTMAX));
        load_network(8192);
        run_sample(8192);
        send_word(OP_FEATURE, 2'd1, 6'd5, 6'd63, 16'sh1000, 1'b1);

        // 16 inputs, layer count clamped to four, unknown codes act as linear
        set_network(16, 7, 24'd0, 12'hFFF);
        load_network(512);
        run_sample(4096);

        // Random shapes with all activation codes
        while (words_sent < 250)
        begin
            layers = $urandom_range(1, 4);
            widths = 24'($urandom);
            for (int l = 0; l < layers; l++)
                widths[6*l +: 6] = 6'($urandom_range(0, 5));
            set_network($urandom_range(1, 6), layers, widths, 12'($urandom));
            case ($urandom_range(2))
                0: load_network(2048);
                1: load_network(8192);
                default: load_network(32767);
            endcase
            repeat ($urandom_range(2, 4)) run_sample(($urandom_range(1) == 1) ? 8192 : 32767);
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Ran %0d samples through %0d words; checked %0d result words.",
                 samples, words_sent, results_seen);
        $display("Shapes covered softmax, curves, leaky, clamped lengths and saturation.");
        if (errors == 0)
            $display("mlp_forward_inference regression: pass");
        else
            $display("mlp_forward_inference regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mlp_pkg.sv
sv/mlp_ram.sv
sv/mlp_act.sv
sv/mlp_div.sv
sv/mlp_forward_inference.sv
verif/mlp_result_checker.sv
verif/mlp_forward_inference_test.sv
